// ----- hdl/tcpqs_pkg.sv -----
`default_nettype none

package tcpqs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 16;

    localparam int REQ_W   = 2;
    localparam int TAG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int SEL_W   = 3;
    localparam int CNT_W   = 5;
    localparam int LIMIT_W = 5;
    localparam int CTR_W   = 32;
    localparam int STAT_W  = 48;
    localparam int ACT_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam int IN_FIELDS_W  = TAG_W + TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = REQ_W + SEL_W;
    localparam int OUT_FIELDS_W = TAG_W + TIME_W + 2 * CNT_W + STAT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 1 + ACT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_HIGH = 2'd0,
        REQ_LOW  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_STAT = 2'd3
    } req_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_IDLE = 2'd0,
        ACT_HIGH = 2'd1,
        ACT_LOW  = 2'd2
    } act_t;

    localparam logic [SEL_W-1:0] SEL_HI_REQ  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_HI_REJ  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_LO_REQ  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_LO_REJ  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_IDLE    = 3'd4;
    localparam logic [SEL_W-1:0] SEL_HI_WAIT = 3'd5;
    localparam logic [SEL_W-1:0] SEL_LO_WAIT = 3'd6;

    typedef struct packed {
        logic take;
        logic pop;
        logic acc;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/two_class_priority_queue_scheduler_core.sv -----
`default_nettype none

// Two-class strict-priority scheduler with tail drop. Each input word is a high-class
// request, a low-class request, a service tick or a statistic read, and yields exactly
// one output word. A tick that pops an entry runs the queue RAM read, then the
// registered read data and wait subtraction, then the saturating wait-sum add; no new
// word is taken until these are done. The single output register frees the input side
// as soon as its word is taken. queue_limit is written through the cfg channel (always
// ready); the user must write it only while idle, which the block does not enforce.

module two_class_priority_queue_scheduler_core
    import tcpqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tag_in[15:0], time_value[47:16]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0], stat_select[4:2]
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // served_tag[15:0], waited_time[47:16], high_queue_count[52:48],
    // low_queue_count[57:53], stat_value[105:58], zero pad above
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // admitted[0], service_action[2:1]
    output logic [OUT_USER_W-1:0]      m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LIMIT_W-1:0]    cfg_data
);

    cmd_t              cmd;
    status_t           st;
    logic              out_admitted;
    act_t              out_action;
    logic [TAG_W-1:0]  out_tag;
    logic [TIME_W-1:0] out_wait;
    logic [CNT_W-1:0]  out_hi_cnt, out_lo_cnt;
    logic [STAT_W-1:0] out_stat;

    assign cfg_ready = 1'b1;

    tcpqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .st        (st),
        .cmd       (cmd)
    );

    tcpqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_req       (req_t'(s_tuser[REQ_W-1:0])),
        .in_tag       (s_tdata[TAG_W-1:0]),
        .in_time      (s_tdata[TAG_W+TIME_W-1:TAG_W]),
        .in_sel       (s_tuser[REQ_W+SEL_W-1:REQ_W]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .out_admitted (out_admitted),
        .out_action   (out_action),
        .out_tag      (out_tag),
        .out_wait     (out_wait),
        .out_hi_cnt   (out_hi_cnt),
        .out_lo_cnt   (out_lo_cnt),
        .out_stat     (out_stat)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                      out_stat, out_lo_cnt, out_hi_cnt, out_wait, out_tag};
    assign m_tuser = {out_action, out_admitted};

`ifndef ASSERT_OFF
    a_adm_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_admitted && (out_action != ACT_IDLE)))
        else $error("admitted and served in one word");

    a_pop_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> cmd.acc)
        else $error("wait sum not updated after pop");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !st.is_pop) |=> m_tvalid)
        else $error("one-cycle result missing");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((32'(out_hi_cnt) <= QUEUE_DEPTH) && (32'(out_lo_cnt) <= QUEUE_DEPTH)))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

// ----- hdl/tcpqs_ram.sv -----
`default_nettype none

module tcpqs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/tcpqs_datapath.sv -----
`default_nettype none

module tcpqs_datapath
    import tcpqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 st,
    input  wire req_t               in_req,
    input  wire logic [TAG_W-1:0]   in_tag,
    input  wire logic [TIME_W-1:0]  in_time,
    input  wire logic [SEL_W-1:0]   in_sel,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_data,
    output logic                    out_admitted,
    output act_t                    out_action,
    output logic [TAG_W-1:0]        out_tag,
    output logic [TIME_W-1:0]       out_wait,
    output logic [CNT_W-1:0]        out_hi_cnt,
    output logic [CNT_W-1:0]        out_lo_cnt,
    output logic [STAT_W-1:0]       out_stat
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TAG_BITS + TIME_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        return (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   hi_head_reg, hi_tail_reg, lo_head_reg, lo_tail_reg;
    logic [QCNT_W-1:0]  hi_cnt_reg, lo_cnt_reg, hi_cnt_next, lo_cnt_next;
    logic [CTR_W-1:0]   hi_req_reg, hi_rej_reg, lo_req_reg, lo_rej_reg, idle_reg;
    logic [STAT_W-1:0]  hi_sum_reg, lo_sum_reg;
    logic               pop_hi_reg;
    logic [TIME_W-1:0]  time_reg;

    logic               adm_reg;
    act_t               act_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [TIME_W-1:0]  wait_reg;
    logic [CNT_W-1:0]   ohi_reg, olo_reg;
    logic [STAT_W-1:0]  stat_reg;

    logic               hi_room, lo_room, hi_we, lo_we;
    logic [31:0]        tag_wide, rd_tag_wide;
    logic [ENTRY_W-1:0] wr_entry, hi_rd, lo_rd, pop_entry;
    logic [TIME_W-1:0]  pop_wait;
    logic [STAT_W-1:0]  stat_mux, acc_base, sum_next;
    logic [STAT_W:0]    sum_wide;

    assign hi_room = (32'(hi_cnt_reg) < 32'(limit_reg)) && (32'(hi_cnt_reg) < QUEUE_DEPTH);
    assign lo_room = (32'(lo_cnt_reg) < 32'(limit_reg)) && (32'(lo_cnt_reg) < QUEUE_DEPTH);
    assign hi_we   = cmd.take && (in_req == REQ_HIGH) && hi_room;
    assign lo_we   = cmd.take && (in_req == REQ_LOW) && lo_room;

    assign st.is_pop = (in_req == REQ_TICK) && ((hi_cnt_reg != '0) || (lo_cnt_reg != '0));

    assign tag_wide = {{(32 - TAG_W){1'b0}}, in_tag};
    assign wr_entry = {tag_wide[TAG_BITS-1:0], in_time};

    tcpqs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
        .clk     (clk),
        .wr_en   (hi_we),
        .wr_addr (hi_tail_reg),
        .wr_data (wr_entry),
        .rd_en   (cmd.take),
        .rd_addr (hi_head_reg),
        .rd_data (hi_rd)
    );

    tcpqs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
        .clk     (clk),
        .wr_en   (lo_we),
        .wr_addr (lo_tail_reg),
        .wr_data (wr_entry),
        .rd_en   (cmd.take),
        .rd_addr (lo_head_reg),
        .rd_data (lo_rd)
    );

    assign pop_entry   = pop_hi_reg ? hi_rd : lo_rd;
    assign rd_tag_wide = 32'(pop_entry[ENTRY_W-1:TIME_W]);
    assign pop_wait    = time_reg - pop_entry[TIME_W-1:0];

    assign acc_base = pop_hi_reg ? hi_sum_reg : lo_sum_reg;
    assign sum_wide = {1'b0, acc_base} + {{(STAT_W + 1 - TIME_W){1'b0}}, wait_reg};
    assign sum_next = (sum_wide >= {1'b0, {STAT_W{1'b1}}}) ? {STAT_W{1'b1}}
                                                          : sum_wide[STAT_W-1:0];

    always_comb
    begin
        hi_cnt_next = hi_cnt_reg;
        lo_cnt_next = lo_cnt_reg;
        if (hi_we)
        begin
            hi_cnt_next = hi_cnt_reg + 1'b1;
        end
        if (lo_we)
        begin
            lo_cnt_next = lo_cnt_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            if (pop_hi_reg)
            begin
                hi_cnt_next = hi_cnt_reg - 1'b1;
            end
            else
            begin
                lo_cnt_next = lo_cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (in_sel)
            SEL_HI_REQ:  stat_mux = {{(STAT_W - CTR_W){1'b0}}, hi_req_reg};
            SEL_HI_REJ:  stat_mux = {{(STAT_W - CTR_W){1'b0}}, hi_rej_reg};
            SEL_LO_REQ:  stat_mux = {{(STAT_W - CTR_W){1'b0}}, lo_req_reg};
            SEL_LO_REJ:  stat_mux = {{(STAT_W - CTR_W){1'b0}}, lo_rej_reg};
            SEL_IDLE:    stat_mux = {{(STAT_W - CTR_W){1'b0}}, idle_reg};
            SEL_HI_WAIT: stat_mux = hi_sum_reg;
            SEL_LO_WAIT: stat_mux = lo_sum_reg;
            default:     stat_mux = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            hi_head_reg <= '0;
            hi_tail_reg <= '0;
            hi_cnt_reg  <= '0;
            lo_head_reg <= '0;
            lo_tail_reg <= '0;
            lo_cnt_reg  <= '0;
            hi_req_reg  <= '0;
            hi_rej_reg  <= '0;
            lo_req_reg  <= '0;
            lo_rej_reg  <= '0;
            idle_reg    <= '0;
            hi_sum_reg  <= '0;
            lo_sum_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            hi_cnt_reg <= hi_cnt_next;
            lo_cnt_reg <= lo_cnt_next;
            if (hi_we)
            begin
                hi_tail_reg <= ptr_inc(hi_tail_reg);
            end
            if (lo_we)
            begin
                lo_tail_reg <= ptr_inc(lo_tail_reg);
            end
            if (cmd.take)
            begin
                unique case (in_req)
                    REQ_HIGH:
                    begin
                        hi_req_reg <= sat_inc(hi_req_reg);
                        if (!hi_room)
                        begin
                            hi_rej_reg <= sat_inc(hi_rej_reg);
                        end
                    end
                    REQ_LOW:
                    begin
                        lo_req_reg <= sat_inc(lo_req_reg);
                        if (!lo_room)
                        begin
                            lo_rej_reg <= sat_inc(lo_rej_reg);
                        end
                    end
                    REQ_TICK:
                    begin
                        if (!st.is_pop)
                        begin
                            idle_reg <= sat_inc(idle_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.pop)
            begin
                if (pop_hi_reg)
                begin
                    hi_head_reg <= ptr_inc(hi_head_reg);
                end
                else
                begin
                    lo_head_reg <= ptr_inc(lo_head_reg);
                end
            end
            if (cmd.acc)
            begin
                if (pop_hi_reg)
                begin
                    hi_sum_reg <= sum_next;
                end
                else
                begin
                    lo_sum_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pop_hi_reg <= (hi_cnt_reg != '0);
            time_reg   <= in_time;
        end
        if (cmd.take && !st.is_pop)
        begin
            adm_reg  <= hi_we || lo_we;
            act_reg  <= ACT_IDLE;
            tag_reg  <= '0;
            wait_reg <= '0;
            ohi_reg  <= CNT_W'(hi_cnt_next);
            olo_reg  <= CNT_W'(lo_cnt_next);
            stat_reg <= (in_req == REQ_STAT) ? stat_mux : '0;
        end
        else if (cmd.pop)
        begin
            adm_reg  <= 1'b0;
            act_reg  <= pop_hi_reg ? ACT_HIGH : ACT_LOW;
            tag_reg  <= rd_tag_wide[TAG_W-1:0];
            wait_reg <= pop_wait;
            ohi_reg  <= CNT_W'(hi_cnt_next);
            olo_reg  <= CNT_W'(lo_cnt_next);
            stat_reg <= '0;
        end
    end

    assign out_admitted = adm_reg;
    assign out_action   = act_reg;
    assign out_tag      = tag_reg;
    assign out_wait     = wait_reg;
    assign out_hi_cnt   = ohi_reg;
    assign out_lo_cnt   = olo_reg;
    assign out_stat     = stat_reg;

endmodule

`default_nettype wire

// ----- hdl/tcpqs_ctrl.sv -----
`default_nettype none

module tcpqs_ctrl
    import tcpqs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_ACC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   take;

    assign in_ready = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign take     = in_ready && in_valid;

    assign cmd.take = take;
    assign cmd.pop  = (state_reg == S_READ);
    assign cmd.acc  = (state_reg == S_ACC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && st.is_pop)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_ACC;
            S_ACC:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if ((take && !st.is_pop) || cmd.pop)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

`default_nettype wire
